@@ src/bsmm_pkg.sv @@
// Package for the bounded min/max stack: sizes, status codes and sequencer states.
// No dependencies; imported by bounded_stack_min_max_top.
package bsmm_pkg;

    localparam int unsigned DEPTH_DEF  = 64;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned FILL_W     = 7;
    localparam int unsigned STATUS_W   = 2;
    // result tdata: popped, top, largest, smallest, fill, padded to whole bytes
    localparam int unsigned RES_BITS   = 4 * WORD_W + FILL_W;
    localparam int unsigned M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

endpackage

@@ src/bounded_stack_min_max_top.sv @@
// Bounded LIFO stack of signed 32-bit words with top/min/max/fill reporting.
// Holds the word memory, the scan sequencer and the shared compare unit.
// Depends on bsmm_pkg.
//
//  channel  | dir | tuser            | tdata (lowest bit up)
//  ---------+-----+------------------+------------------------------------------------
//  s_axis   | in  | [0] kind         | [31:0] push_value
//  m_axis   | out | [1:0] status     | popped, top, largest, smallest (32 each), fill(7)
//
// Sweep: a request reads L words, L = words held after a push, or
//   held + 1 after a pop (the popped word is read in the same sweep); the
//   scan reads one memory word per cycle through the single read port.
//   Refused pops skip the scan.
// Reset: synchronous, active low; empties the stack. The memory is not cleared.
// Stalls: a finished result sits in the output register; the next request is
//   taken meanwhile and waits at its end until that register drains.
module bounded_stack_min_max_top
    import bsmm_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [WORD_W-1:0]    s_axis_tdata,   // [31:0] push_value
    input  logic                 s_axis_tuser,   // [0] kind: 0 push, 1 pop
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] popped, [63:32] top,
                                                 // [95:64] largest, [127:96] smallest,
                                                 // [134:128] fill_count, [135] zero
    output logic [STATUS_W-1:0]  m_axis_tuser    // [1:0] status
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // word store, one write and one registered read per cycle
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_mem_q;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count;       // words held after the current request
    t_status             r_status;
    logic                r_is_pop;      // successful pop: last read is the popped word
    logic [AW-1:0]       r_end;         // last address of the sweep
    logic [AW-1:0]       r_rd_addr;
    logic                r_issue;       // read addresses still to go
    logic                r_dv;          // r_mem_q valid this cycle
    logic                r_dlast;
    logic                r_dfirst;
    logic                r_dpop;

    logic signed [WORD_W-1:0] r_popped, r_top, r_max, r_min;

    logic                r_m_valid;
    t_status             r_m_status;
    logic [M_TDATA_W-1:0] r_m_data;

    logic                accept, is_full, is_empty, wr_en, rd_en, out_free;
    logic [CW-1:0]       new_count;
    logic [AW-1:0]       new_end;
    logic                new_scan;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_full       = (r_count == CW'(DEPTH));
    assign is_empty      = (r_count == '0);
    assign wr_en         = accept && (s_axis_tuser == OP_PUSH) && !is_full;
    assign rd_en         = (r_state == S_SCAN) && r_issue;
    assign out_free      = !r_m_valid || m_axis_tready;

    // request decode: new fill and the last address the sweep must read
    always_comb begin
        if (s_axis_tuser == OP_PUSH) begin
            new_count = is_full ? r_count : r_count + CW'(1);
            new_end   = AW'(new_count - CW'(1));
            new_scan  = (new_count != '0);
        end else begin
            new_count = is_empty ? r_count : r_count - CW'(1);
            new_end   = AW'(new_count);
            new_scan  = !is_empty;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = new_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (r_dv && r_dlast) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_HOLD: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory: no reset, unwritten words are never read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(r_count)] <= s_axis_tdata;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rd_addr];
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= rd_en;
            if (accept) begin
                r_count <= new_count;
                r_issue <= new_scan;
            end else if (rd_en && (r_rd_addr == r_end)) begin
                r_issue <= 1'b0;
            end
        end
    end

    // sweep and shared signed compare
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= (s_axis_tuser == OP_PUSH) ? (is_full ? ST_FULL : ST_OK)
                                                   : (is_empty ? ST_EMPTY : ST_OK);
            r_is_pop  <= (s_axis_tuser == OP_POP) && !is_empty;
            r_end     <= new_end;
            r_rd_addr <= '0;
            r_popped  <= '0;
            r_top     <= '0;
            r_max     <= '0;
            r_min     <= '0;
        end else if (rd_en) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
        if (rd_en) begin
            r_dlast  <= (r_rd_addr == r_end);
            r_dfirst <= (r_rd_addr == '0);
            r_dpop   <= r_is_pop && (r_rd_addr == r_end);
        end
        if (r_dv) begin
            if (r_dpop) begin
                r_popped <= r_mem_q;
            end else begin
                r_top <= r_mem_q;
                if (r_dfirst || ($signed(r_mem_q) > r_max)) begin
                    r_max <= r_mem_q;
                end
                if (r_dfirst || ($signed(r_mem_q) < r_min)) begin
                    r_min <= r_mem_q;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_m_status <= r_status;
            r_m_data   <= M_TDATA_W'({FILL_W'(r_count), r_min, r_max, r_top, r_popped});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_status;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted push did not grow the stack");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

    a_data_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN))
        else $error("memory data returned outside the sweep");

    a_empty_zero_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_status == ST_EMPTY)) |-> (r_m_data[4*WORD_W +: FILL_W] == '0))
        else $error("refused pop reports a nonzero fill");

endmodule
